// ----- design/quat_to_axis_angle_macros.svh -----
// Assertion macros shared by the quaternion to axis-angle checker.
`ifndef QUAT_TO_AXIS_ANGLE_MACROS_SVH
`define QUAT_TO_AXIS_ANGLE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define QAA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define QAA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/qaa_pkg.sv -----
// Shared constants and types for the quaternion to axis-angle converter.
`default_nettype none

package qaa_pkg;

    localparam int COMP_FRAC_BITS_DEF = 30;

    // arc cosine recurrence: Q1.62 work value, 64 turn bits
    localparam int WORK_FRAC  = 62;
    localparam int WORK_W     = 63;
    localparam int TURN_W     = 64;
    localparam int ACOS_STEPS = 64;

    // pi in Q2.62, rounded to nearest
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // near-identity threshold is 1 - 1/NEAR_ONE_DEN
    localparam logic [63:0] NEAR_ONE_DEN = 64'd100000000;

    // state handed from one arc cosine cell to the next
    typedef struct packed {
        logic [WORK_W-1:0] m;
        logic              neg;
        logic [TURN_W-1:0] t;
    } acos_state_t;

endpackage

`default_nettype wire

// ----- design/qaa_delay.sv -----
// Enabled delay line that keeps side data aligned with the pipeline.
`default_nettype none

module qaa_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign q = d;
        end
        else begin : g_line
            logic [W-1:0] line_reg [DEPTH];

            // advance the line on every pipeline step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    line_reg[0] <= d;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        line_reg[i] <= line_reg[i-1];
                    end
                end
            end

            assign q = line_reg[DEPTH-1];
        end
    endgenerate

endmodule

`default_nettype wire

// ----- design/qaa_acos_cell.sv -----
// One step of the cosine doubling recurrence: yields one bit of acos(w)/pi.
`default_nettype none

module qaa_acos_cell import qaa_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  acos_state_t st_in,
    output acos_state_t st_out
);

    localparam logic [63:0] WORK_ONE = 64'(1) << WORK_FRAC;

    logic [30:0]       mh;
    logic [31:0]       ml;
    logic [61:0]       phh_reg;
    logic [62:0]       phl_reg;
    logic [63:0]       pll_reg;
    logic              b_reg;
    logic [TURN_W-1:0] t_reg;
    logic [124:0]      sq;
    logic [63:0]       u;
    logic              ge;
    logic [WORK_W-1:0] sm;
    acos_state_t       st_next;
    acos_state_t       st_reg;

    assign mh = st_in.m[62:32];
    assign ml = st_in.m[31:0];

    // stage A: partial products of the square, append the sign bit to the turns
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phh_reg <= 62'(mh) * 62'(mh);
            phl_reg <= 63'(mh) * 63'(ml);
            pll_reg <= 64'(ml) * 64'(ml);
            b_reg   <= st_in.neg;
            t_reg   <= {st_in.t[TURN_W-2:0], st_in.neg};
        end
    end

    // stage B: 2c^2 - 1 with truncated square, fold the sign
    always_comb
    begin
        sq = 125'({phh_reg, 64'b0}) + 125'({phl_reg, 33'b0}) + 125'(pll_reg);
        u  = sq[124:61];
        ge = (u >= WORK_ONE);
        sm = WORK_W'(ge ? (u - WORK_ONE) : (WORK_ONE - u));
        st_next.m   = sm;
        st_next.neg = (ge == b_reg) && (sm != '0);
        st_next.t   = t_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

`default_nettype wire

// ----- design/qaa_sqrt_cell.sv -----
// One digit of the restoring integer square root.
`default_nettype none

module qaa_sqrt_cell #(
    parameter int R_W = 33,
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             en,
    input  logic [2*R_W-1:0] s_in,
    input  logic [R_W:0]     rem_in,
    input  logic [R_W-1:0]   root_in,
    output logic [2*R_W-1:0] s_out,
    output logic [R_W:0]     rem_out,
    output logic [R_W-1:0]   root_out
);

    logic [R_W+2:0]   rem_sh;
    logic [R_W+2:0]   trial;
    logic [R_W+2:0]   diff;
    logic             ge;
    logic [2*R_W-1:0] s_reg;
    logic [R_W:0]     rem_reg;
    logic [R_W:0]     rem_next;
    logic [R_W-1:0]   root_reg;
    logic [R_W-1:0]   root_next;

    // bring down the next bit pair and try root*4+1
    always_comb
    begin
        rem_sh    = {rem_in, s_in[2*IDX +: 2]};
        trial     = {1'b0, root_in, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rem_next  = ge ? diff[R_W:0] : rem_sh[R_W:0];
        root_next = {root_in[R_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign s_out    = s_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

// ----- design/qaa_div_cell.sv -----
// One quotient bit of the restoring division of a component by the length.
`default_nettype none

module qaa_div_cell #(
    parameter int R_W   = 33,
    parameter int Q_W   = 31,
    parameter int FIRST = 0
) (
    input  logic           clk,
    input  logic           en,
    input  logic [R_W-1:0] r_in,
    input  logic [R_W-1:0] rem_in,
    input  logic [Q_W-1:0] q_in,
    output logic [R_W-1:0] r_out,
    output logic [R_W-1:0] rem_out,
    output logic [Q_W-1:0] q_out
);

    logic [R_W:0]   v;
    logic [R_W:0]   d;
    logic           ge;
    logic [R_W-1:0] r_reg;
    logic [R_W-1:0] rem_reg;
    logic [R_W-1:0] rem_next;
    logic [Q_W-1:0] q_reg;
    logic [Q_W-1:0] q_next;

    // first cell tests the integer part, later cells shift in a zero bit
    always_comb
    begin
        v        = (FIRST != 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
        d        = v - {1'b0, r_in};
        ge       = (v >= {1'b0, r_in});
        rem_next = ge ? d[R_W-1:0] : v[R_W-1:0];
        q_next   = {q_in[Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign r_out   = r_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

// ----- design/quat_to_axis_angle.sv -----
// Quaternion to axis-angle converter, top level.
//
// Input beats carry one quaternion (w, x, y, z) in signed Q1.F on s_tdata;
// output beats carry the angle 2*acos(w) in unsigned Q3.(F-2) radians and
// the unit axis (x, y, z) in signed Q1.F on m_tdata. One output per input.
// When |w| is at or above the near-one threshold the output is angle 0 and
// axis (1, 0, 0); a zero vector part gives a zero axis.
// Throughput: one quaternion per cycle, sustained while the output is not stalled.
// The arc cosine is a row of 64 two-stage cells, one turn bit each (square
// split into partial products), followed by two stages for the multiply
// by pi. The axis path is squares, sum, F+3 square-root cells and F+1
// division cells per component, padded to the same length.
// Reset clears all valid bits; no beat is presented until new input comes.
// When m_tready is low the output register holds its beat and the pipeline
// keeps accepting until its last stage is also full, then s_tready drops.
`default_nettype none

module quat_to_axis_angle import qaa_pkg::*; #(
    parameter int COMP_FRAC_BITS = COMP_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // quat_w, quat_x, quat_y, quat_z
    input  logic [((4*(COMP_FRAC_BITS+2)+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // rot_angle, axis_x, axis_y, axis_z
    output logic [((4*COMP_FRAC_BITS+14)/8)*8-1:0] m_tdata
);

    localparam int F       = COMP_FRAC_BITS;
    localparam int IO_W    = F + 2;
    localparam int MAG_W   = F + 2;
    localparam int ANG_W   = F + 1;
    localparam int R_W     = F + 3;
    localparam int S_W     = 2 * R_W;
    localparam int Q_W     = F + 1;
    localparam int SQRT_N  = R_W;
    localparam int DIV_N   = F + 1;
    localparam int ANG_BR  = 2 * ACOS_STEPS + 2;
    localparam int AX_BR   = 2 + SQRT_N + DIV_N;
    localparam int BR      = (ANG_BR > AX_BR) ? ANG_BR : AX_BR;
    localparam int D_ANG   = BR - ANG_BR;
    localparam int D_AX    = BR - AX_BR;
    localparam int N_ST    = BR + 2;
    localparam int OUT_W   = ((4*F + 14) / 8) * 8;
    localparam int AXD_W   = 3*MAG_W + 4;
    localparam int SIDE1_W = 3*MAG_W + 5;
    localparam int SIDE2_W = 5;

    localparam logic [63:0]    ONE_Q     = 64'(1) << F;
    localparam logic [63:0]    NEAR_LIM  = ONE_Q / NEAR_ONE_DEN;
    localparam logic [MAG_W-1:0] ONE_M   = MAG_W'(ONE_Q);
    localparam logic [MAG_W-1:0] LIM_M   = MAG_W'(NEAR_LIM);
    localparam logic [127:0]   ANG_HALF  = 128'(1) << (126 - F);

    // ---------------------------------------------------------------
    // flow control
    // ---------------------------------------------------------------
    logic [N_ST-1:0] vld_reg;
    logic            out_valid_reg;
    logic            en;
    logic            out_load;

    assign en       = !vld_reg[N_ST-1] || !out_valid_reg || m_tready;
    assign out_load = en && vld_reg[N_ST-1];
    assign s_tready = en;

    // advance the valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[N_ST-2:0], s_tvalid};
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // input stage: sign and magnitude, near-identity test
    // ---------------------------------------------------------------
    logic [IO_W-1:0]   raw [4];
    logic              fneg [4];
    logic [MAG_W-1:0]  fmag [4];
    logic [63:0]       wext;
    logic              near_in;

    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++) begin : g_field
            assign raw[gi]  = s_tdata[gi*IO_W +: IO_W];
            assign fneg[gi] = raw[gi][IO_W-1];
            assign fmag[gi] = fneg[gi] ? (~raw[gi] + 1'b1) : raw[gi];
        end
    endgenerate

    assign wext    = 64'(fmag[0]) << (WORK_FRAC - F);
    assign near_in = !((fmag[0] < ONE_M) && ((ONE_M - fmag[0]) > LIM_M));

    logic [WORK_W-1:0] m0_reg;
    logic              neg0_reg;
    logic [MAG_W-1:0]  vmag_reg [3];
    logic              vneg_reg [3];
    logic              near0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg    <= wext[WORK_W-1:0];
            neg0_reg  <= fneg[0] && (wext != '0);
            near0_reg <= near_in;
            for (int i = 0; i < 3; i++)
            begin
                vmag_reg[i] <= fmag[i+1];
                vneg_reg[i] <= fneg[i+1];
            end
        end
    end

    // ---------------------------------------------------------------
    // angle path: row of arc cosine cells, then turns times pi
    // ---------------------------------------------------------------
    acos_state_t       ac [ACOS_STEPS+1];
    logic [TURN_W-1:0] t_d;

    assign ac[0].m   = m0_reg;
    assign ac[0].neg = neg0_reg;
    assign ac[0].t   = '0;

    generate
        for (gi = 0; gi < ACOS_STEPS; gi++) begin : g_acos
            qaa_acos_cell u_cell (
                .clk    (clk),
                .en     (en),
                .st_in  (ac[gi]),
                .st_out (ac[gi+1])
            );
        end
    endgenerate

    qaa_delay #(.W(TURN_W), .DEPTH(D_ANG)) u_ang_pad (
        .clk (clk),
        .en  (en),
        .d   (ac[ACOS_STEPS].t),
        .q   (t_d)
    );

    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic [64:0] mid_reg;
    logic [63:0] p00b_reg;
    logic [63:0] p11b_reg;

    // partial products, then the middle sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= 64'(t_d[31:0])  * 64'(PI_Q62[31:0]);
            p01_reg  <= 64'(t_d[31:0])  * 64'(PI_Q62[63:32]);
            p10_reg  <= 64'(t_d[63:32]) * 64'(PI_Q62[31:0]);
            p11_reg  <= 64'(t_d[63:32]) * 64'(PI_Q62[63:32]);
            mid_reg  <= 65'(p01_reg) + 65'(p10_reg);
            p00b_reg <= p00_reg;
            p11b_reg <= p11_reg;
        end
    end

    // ---------------------------------------------------------------
    // axis path: squares, sum, square root, three divisions
    // ---------------------------------------------------------------
    logic [AXD_W-1:0] axd_in;
    logic [AXD_W-1:0] axd_out;

    generate
        for (gi = 0; gi < 3; gi++) begin : g_axd
            assign axd_in[gi*MAG_W +: MAG_W] = vmag_reg[gi];
            assign axd_in[3*MAG_W + gi]      = vneg_reg[gi];
        end
    endgenerate
    assign axd_in[3*MAG_W + 3] = near0_reg;

    qaa_delay #(.W(AXD_W), .DEPTH(D_AX)) u_ax_pad (
        .clk (clk),
        .en  (en),
        .d   (axd_in),
        .q   (axd_out)
    );

    logic [2*MAG_W-1:0] sq_reg [3];
    logic [MAG_W-1:0]   sqmag_reg [3];
    logic [2:0]         sqneg_reg;
    logic               sqnear_reg;
    logic [S_W-1:0]     s_reg;
    logic [MAG_W-1:0]   smag_reg [3];
    logic [2:0]         sneg_reg;
    logic               snear_reg;

    // square each component, then sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]    <= (2*MAG_W)'(axd_out[i*MAG_W +: MAG_W])
                              * (2*MAG_W)'(axd_out[i*MAG_W +: MAG_W]);
                sqmag_reg[i] <= axd_out[i*MAG_W +: MAG_W];
                smag_reg[i]  <= sqmag_reg[i];
            end
            sqneg_reg  <= axd_out[3*MAG_W +: 3];
            sqnear_reg <= axd_out[3*MAG_W + 3];
            s_reg      <= S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
            sneg_reg   <= sqneg_reg;
            snear_reg  <= sqnear_reg;
        end
    end

    // carry magnitudes and flags alongside the square root
    logic [SIDE1_W-1:0] side1_in;
    logic [SIDE1_W-1:0] side1_out;

    generate
        for (gi = 0; gi < 3; gi++) begin : g_side1
            assign side1_in[gi*MAG_W +: MAG_W] = smag_reg[gi];
        end
    endgenerate
    assign side1_in[3*MAG_W +: 3]  = sneg_reg;
    assign side1_in[3*MAG_W + 3]   = (s_reg == '0);
    assign side1_in[3*MAG_W + 4]   = snear_reg;

    qaa_delay #(.W(SIDE1_W), .DEPTH(SQRT_N)) u_side1 (
        .clk (clk),
        .en  (en),
        .d   (side1_in),
        .q   (side1_out)
    );

    logic [S_W-1:0] rt_s    [SQRT_N+1];
    logic [R_W:0]   rt_rem  [SQRT_N+1];
    logic [R_W-1:0] rt_root [SQRT_N+1];

    assign rt_s[0]    = s_reg;
    assign rt_rem[0]  = '0;
    assign rt_root[0] = '0;

    generate
        for (gi = 0; gi < SQRT_N; gi++) begin : g_sqrt
            qaa_sqrt_cell #(.R_W(R_W), .IDX(R_W - 1 - gi)) u_cell (
                .clk      (clk),
                .en       (en),
                .s_in     (rt_s[gi]),
                .rem_in   (rt_rem[gi]),
                .root_in  (rt_root[gi]),
                .s_out    (rt_s[gi+1]),
                .rem_out  (rt_rem[gi+1]),
                .root_out (rt_root[gi+1])
            );
        end
    endgenerate

    // carry signs and flags alongside the divisions
    logic [SIDE2_W-1:0] side2_out;

    qaa_delay #(.W(SIDE2_W), .DEPTH(DIV_N)) u_side2 (
        .clk (clk),
        .en  (en),
        .d   (side1_out[3*MAG_W +: SIDE2_W]),
        .q   (side2_out)
    );

    logic [R_W-1:0] dv_r   [3][DIV_N+1];
    logic [R_W-1:0] dv_rem [3][DIV_N+1];
    logic [Q_W-1:0] dv_q   [3][DIV_N+1];

    genvar gl;
    generate
        for (gl = 0; gl < 3; gl++) begin : g_lane
            assign dv_r[gl][0]   = rt_root[SQRT_N];
            assign dv_rem[gl][0] = R_W'(side1_out[gl*MAG_W +: MAG_W]);
            assign dv_q[gl][0]   = '0;
            for (gi = 0; gi < DIV_N; gi++) begin : g_div
                qaa_div_cell #(.R_W(R_W), .Q_W(Q_W), .FIRST((gi == 0) ? 1 : 0)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .r_in    (dv_r[gl][gi]),
                    .rem_in  (dv_rem[gl][gi]),
                    .q_in    (dv_q[gl][gi]),
                    .r_out   (dv_r[gl][gi+1]),
                    .rem_out (dv_rem[gl][gi+1]),
                    .q_out   (dv_q[gl][gi+1])
                );
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // last stage: round, apply signs and special cases
    // ---------------------------------------------------------------
    logic [127:0]     full;
    logic [ANG_W-1:0] ang_next;
    logic [IO_W-1:0]  ax_next [3];
    logic [IO_W-1:0]  qr [3];
    logic             fin_near;
    logic             fin_zero;

    assign fin_near = side2_out[4];
    assign fin_zero = side2_out[3];

    always_comb
    begin
        full = {p11b_reg, 64'b0} + {31'b0, mid_reg, 32'b0} + {64'b0, p00b_reg} + ANG_HALF;
        ang_next = fin_near ? '0 : full[127 -: ANG_W];
        for (int i = 0; i < 3; i++)
        begin
            qr[i] = IO_W'(dv_q[i][DIV_N])
                  + IO_W'({dv_rem[i][DIV_N], 1'b0} >= {1'b0, dv_r[i][DIV_N]});
            ax_next[i] = side2_out[i] ? (IO_W'(0) - qr[i]) : qr[i];
            if (fin_near)
            begin
                ax_next[i] = (i == 0) ? IO_W'(ONE_Q) : '0;
            end
            else if (fin_zero)
            begin
                ax_next[i] = '0;
            end
        end
    end

    logic [ANG_W-1:0] fin_ang_reg;
    logic [IO_W-1:0]  fin_ax_reg [3];
    logic [ANG_W-1:0] out_ang_reg;
    logic [IO_W-1:0]  out_ax_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_ang_reg <= ang_next;
            for (int i = 0; i < 3; i++)
            begin
                fin_ax_reg[i] <= ax_next[i];
            end
        end
        if (out_load)
        begin
            out_ang_reg <= fin_ang_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_ax_reg[i] <= fin_ax_reg[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_ax_reg[2], out_ax_reg[1], out_ax_reg[0], out_ang_reg});

endmodule

`default_nettype wire

// ----- design/qaa_checker.sv -----
// Port-level checker for the quaternion to axis-angle converter, bound to the top.
`default_nettype none
`include "quat_to_axis_angle_macros.svh"

module qaa_checker import qaa_pkg::*; #(
    parameter int COMP_FRAC_BITS = COMP_FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((4*COMP_FRAC_BITS+14)/8)*8-1:0] m_tdata
);

    localparam int F     = COMP_FRAC_BITS;
    localparam int IO_W  = F + 2;
    localparam int ANG_W = F + 1;
    localparam logic signed [IO_W-1:0] ONE_S = IO_W'(64'(1) << F);
    localparam logic signed [IO_W-1:0] MONE_S = IO_W'(0) - ONE_S;

    logic signed [IO_W-1:0] chk_x;
    logic signed [IO_W-1:0] chk_y;
    logic signed [IO_W-1:0] chk_z;
    logic                   ax_ok;

    assign chk_x = m_tdata[ANG_W +: IO_W];
    assign chk_y = m_tdata[ANG_W + IO_W +: IO_W];
    assign chk_z = m_tdata[ANG_W + 2*IO_W +: IO_W];

    // every axis component stays within [-1, 1]
    assign ax_ok = (chk_x <= ONE_S) && (chk_x >= MONE_S)
                && (chk_y <= ONE_S) && (chk_y >= MONE_S)
                && (chk_z <= ONE_S) && (chk_z >= MONE_S);

    `QAA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output beat dropped while stalled")
    `QAA_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "output beat changed while stalled")
    `QAA_ASSERT_NOW(a_axis_range, m_tvalid, ax_ok, "axis component beyond unit range")
    `QAA_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind quat_to_axis_angle qaa_checker #(.COMP_FRAC_BITS(COMP_FRAC_BITS)) u_qaa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_quat_to_axis_angle.sv -----
// Testbench for the quaternion to axis-angle converter: directed corners, random streams, checks.
`default_nettype none

module tb_quat_to_axis_angle import qaa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int F          = 30;
    localparam int WD_LIMIT   = 6000;
    localparam int DRAIN_WAIT = 140;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_t;

    typedef struct {
        logic [30:0]        angle;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
    } axang_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // quat_w, quat_x, quat_y, quat_z
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // rot_angle, axis_x, axis_y, axis_z, pad
    logic [127:0] m_tdata;

    axang_t expected_axang[$];
    int     errors;
    int     sent;
    int     received;
    int     idle_pct;
    int     stall_pct;
    int     quiet_cycles;
    bit     timed_out;

    quat_to_axis_angle dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // sign and magnitude of a Q1.30 field
    function automatic logic [31:0] mag32(input logic [31:0] v, output bit neg);
    begin
        neg = v[31];
        mag32 = neg ? (~v + 32'd1) : v;
    end
    endfunction

    // acos(w)/pi as a Q0.64 turn fraction, by repeated cosine doubling
    function automatic logic [63:0] acos_turn_bits(input logic [31:0] wmag, input bit wneg);
        logic [127:0] m;
        logic [127:0] u;
        logic [127:0] sm;
        logic [63:0]  t;
        bit           neg;
        bit           b;
        bit           sn;
    begin
        m   = 128'(wmag) << (WORK_FRAC - F);
        neg = wneg && (m != 0);
        t   = '0;
        for (int k = 0; k < ACOS_STEPS; k++)
        begin
            b = neg;
            t = {t[62:0], b};
            u = (m * m) >> (WORK_FRAC - 1);
            if (u >= (128'd1 << WORK_FRAC))
            begin
                sm = u - (128'd1 << WORK_FRAC);
                sn = 1'b0;
            end
            else
            begin
                sm = (128'd1 << WORK_FRAC) - u;
                sn = 1'b1;
            end
            m   = sm;
            neg = (sn != b) && (sm != 0);
        end
        acos_turn_bits = t;
    end
    endfunction

    // expected angle and unit axis for one quaternion
    function automatic axang_t convert_quat(input quat_t q);
        axang_t       r;
        logic [31:0]  mags[3];
        bit           negs[3];
        logic [31:0]  wm;
        bit           wn;
        logic [127:0] prod;
        logic [127:0] ssum;
        logic [127:0] c;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [63:0]  root;
        logic [31:0]  comp[3];
    begin
        wm      = mag32(q.w, wn);
        mags[0] = mag32(q.x, negs[0]);
        mags[1] = mag32(q.y, negs[1]);
        mags[2] = mag32(q.z, negs[2]);
        // hold identity near |w| = 1
        if (!(wm < (32'd1 << F) && ((32'd1 << F) - wm) > ((32'd1 << F) / 32'd100000000)))
        begin
            r.angle = '0;
            r.ax    = 32'sd1 << F;
            r.ay    = '0;
            r.az    = '0;
            return r;
        end
        prod    = 128'(acos_turn_bits(wm, wn)) * 128'(PI_Q62);
        prod    = prod + (128'd1 << (126 - F));
        prod    = prod >> (127 - F);
        r.angle = prod[30:0];
        ssum = 128'(mags[0]) * mags[0] + 128'(mags[1]) * mags[1] + 128'(mags[2]) * mags[2];
        if (ssum == 0)
        begin
            r.ax = '0;
            r.ay = '0;
            r.az = '0;
            return r;
        end
        root = '0;
        for (int bt = 63; bt >= 0; bt--)
        begin
            c = 128'(root | (64'd1 << bt));
            if (c * c <= ssum)
                root = c[63:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            num = 128'(mags[i]) << F;
            quo = num / root;
            rem = num % root;
            if (rem >= 128'(root) - rem)
                quo = quo + 1;
            comp[i] = negs[i] ? (32'd0 - quo[31:0]) : quo[31:0];
        end
        r.ax = comp[0];
        r.ay = comp[1];
        r.az = comp[2];
        return r;
    end
    endfunction

    // receiver readiness follows the current stall rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each output beat against the oldest expectation
    always @(posedge clk)
    begin
        axang_t got;
        axang_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.angle = m_tdata[30:0];
            got.ax    = m_tdata[62:31];
            got.ay    = m_tdata[94:63];
            got.az    = m_tdata[126:95];
            received++;
            if (expected_axang.size() == 0)
            begin
                errors++;
                $error("unexpected beat: angle %0d axis %0d %0d %0d",
                       got.angle, got.ax, got.ay, got.az);
            end
            else
            begin
                exp_r = expected_axang.pop_front();
                if (got.angle !== exp_r.angle)
                begin
                    errors++;
                    $error("rot_angle: expected %0d, got %0d", exp_r.angle, got.angle);
                end
                if (got.ax !== exp_r.ax)
                begin
                    errors++;
                    $error("axis_x: expected %0d, got %0d", exp_r.ax, got.ax);
                end
                if (got.ay !== exp_r.ay)
                begin
                    errors++;
                    $error("axis_y: expected %0d, got %0d", exp_r.ay, got.ay);
                end
                if (got.az !== exp_r.az)
                begin
                    errors++;
                    $error("axis_z: expected %0d, got %0d", exp_r.az, got.az);
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog: no beat for %0d cycles", WD_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // after an optional idle gap, drive one beat and wait for the handshake
    task automatic send_quat(input quat_t q);
        bit rdy;
    begin
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q.z, q.y, q.x, q.w};
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        expected_axang.push_back(convert_quat(q));
        sent++;
    end
    endtask

    task automatic go_idle();
    begin
        s_tvalid <= 1'b0;
        @(posedge clk);
    end
    endtask

    task automatic wait_drained();
    begin
        while (expected_axang.size() != 0)
            @(posedge clk);
    end
    endtask

    function automatic quat_t mk(input int w, input int x, input int y, input int z);
        quat_t q;
    begin
        q.w = w;
        q.x = x;
        q.y = y;
        q.z = z;
        return q;
    end
    endfunction

    // random unit quaternion; small angles and a zero vector part now and then
    function automatic quat_t rand_unit_quat();
        real th;
        real ux;
        real uy;
        real uz;
        real n;
        real sh;
        int  pick;
    begin
        pick = $urandom_range(99);
        if (pick < 15)
            th = $urandom_range(0, 100000) * 1.0e-9;
        else
            th = $urandom_range(0, 1000000) * 1.0e-6 * 6.283185307179586;
        ux = $urandom_range(0, 2000000) - 1000000.0;
        uy = $urandom_range(0, 2000000) - 1000000.0;
        uz = $urandom_range(0, 2000000) - 1000000.0;
        n  = $sqrt(ux * ux + uy * uy + uz * uz);
        if (n == 0.0 || pick == 99)
        begin
            ux = 0.0;
            uy = 0.0;
            uz = 0.0;
            n  = 1.0;
        end
        sh = $sin(th / 2.0) / n * 1073741824.0;
        return mk($rtoi($cos(th / 2.0) * 1073741824.0),
                  $rtoi(ux * sh), $rtoi(uy * sh), $rtoi(uz * sh));
    end
    endfunction

    task automatic test_corners();
        localparam int ONE = 1 << F;
    begin
        idle_pct  = 0;
        stall_pct = 0;
        send_quat(mk(0, ONE, 0, 0));
        send_quat(mk(0, 0, ONE, 0));
        send_quat(mk(0, 0, 0, -ONE));
        send_quat(mk(ONE, 0, 0, 0));
        send_quat(mk(-ONE, 0, 0, 0));
        send_quat(mk(ONE - 10, 5, 0, 0));
        send_quat(mk(ONE - 11, 5, 0, 0));
        send_quat(mk(-(ONE - 10), 0, 7, 0));
        send_quat(mk(-(ONE - 11), 0, 7, 0));
        send_quat(mk(32'h8000_0000, 1, 2, 3));
        send_quat(mk(32'h7FFF_FFFF, 1, 2, 3));
        send_quat(mk(0, 0, 0, 0));
        send_quat(mk(-ONE / 2, 0, 0, 0));
        send_quat(mk(ONE / 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_quat(mk(-ONE / 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_quat(mk(1, -1, 1, -1));
        send_quat(mk(-1, 0, 0, 1));
        send_quat(mk(759250125, 759250125, 0, 0));
        send_quat(mk(-759250125, 0, -759250125, 0));
        send_quat(mk(ONE / 2, ONE / 2, ONE / 2, ONE / 2));
        go_idle();
    end
    endtask

    task automatic test_unit_stream(input int n, input int ipct, input int spct);
    begin
        idle_pct  = ipct;
        stall_pct = spct;
        repeat (n) send_quat(rand_unit_quat());
        go_idle();
    end
    endtask

    // raw bit patterns, including non-unit and out-of-range words
    task automatic test_raw_patterns(input int n);
    begin
        idle_pct  = 9;
        stall_pct = 9;
        repeat (n) send_quat(mk($urandom, $urandom, $urandom, $urandom));
        go_idle();
    end
    endtask

    // pause the sender until the pipeline has fully drained, then resume
    task automatic test_drain_pause();
    begin
        idle_pct  = 0;
        stall_pct = 55;
        repeat (20) send_quat(rand_unit_quat());
        go_idle();
        wait_drained();
        repeat (20) send_quat(rand_unit_quat());
        go_idle();
    end
    endtask

    initial
    begin
        errors       = 0;
        sent         = 0;
        received     = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        timed_out    = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_unit_stream(150, 0, 0);
        test_unit_stream(150, 55, 0);
        test_unit_stream(150, 0, 55);
        test_unit_stream(100, 9, 9);
        test_raw_patterns(60);
        test_drain_pause();

        wait_drained();
        stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d quaternions (corners, identity threshold, zero axis,", sent);
        $display("  raw words) under idle/stall mixes; %0d results checked", received);
        if (errors == 0 && expected_axang.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/qaa_pkg.sv
design/qaa_delay.sv
design/qaa_acos_cell.sv
design/qaa_sqrt_cell.sv
design/qaa_div_cell.sv
design/quat_to_axis_angle.sv
design/qaa_checker.sv
tb/tb_quat_to_axis_angle.sv
